>>> hw/rtl/smi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_pkg: shared types and constants of the SPIR-V module indexer
// Record and status codes, opcodes the decoder looks at, and the record that
// travels from the decoder through the queue to the table stage.
// ----------------------------------------------------------------------------
package smi_pkg;

	// Fixed widths of the result fields
	localparam int OFF_W  = 20;
	localparam int TYPE_W = 12;

	// Header layout
	localparam int HDR_WORDS      = 5;
	localparam int HDR_BOUND_WORD = 3;

	// Depth of the queue between decoder and table stage (power of two)
	localparam int QUEUE_DEPTH = 4;

	// Opcodes of interest
	localparam logic [15:0] OP_NAME          = 16'd5;
	localparam logic [15:0] OP_MEMBER_NAME   = 16'd6;
	localparam logic [15:0] OP_ENTRY_POINT   = 16'd15;
	localparam logic [15:0] OP_TYPE_VOID     = 16'd19;
	localparam logic [15:0] OP_TYPE_INT      = 16'd21;
	localparam logic [15:0] OP_TYPE_FLOAT    = 16'd22;
	localparam logic [15:0] OP_TYPE_LAST     = 16'd28;
	localparam logic [15:0] OP_TYPE_POINTER  = 16'd32;
	localparam logic [15:0] OP_TYPE_FUNCTION = 16'd33;
	localparam logic [15:0] OP_CONSTANT      = 16'd43;
	localparam logic [15:0] OP_FUNCTION      = 16'd54;
	localparam logic [15:0] OP_VARIABLE      = 16'd59;
	localparam logic [15:0] OP_DECORATE      = 16'd71;

	// Scalar width that marks the 32-bit unsigned int / float
	localparam logic [31:0] SCALAR_BITS_32 = 32'd32;

	typedef enum logic [1:0] {
		REC_NAME,
		REC_DEFINITION,
		REC_DECORATION,
		REC_SUMMARY
	} rec_kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_TOO_SHORT,
		ST_BAD_ID,
		ST_EXTRA_ENTRY,
		ST_NO_ENTRY
	} status_t;

	// One record; prior_link is not part of it and comes from the table stage
	typedef struct packed {
		rec_kind_t          kind;
		logic [31:0]        target_id;
		logic [OFF_W-1:0]   word_offset;
		logic [15:0]        opcode;
		logic [OFF_W-1:0]   types_at;
		logic [OFF_W-1:0]   funcs_at;
		logic [OFF_W-1:0]   names_at;
		logic [TYPE_W-1:0]  int32_type;
		logic [TYPE_W-1:0]  float32_type;
		logic [TYPE_W-1:0]  voidfunc_type;
		status_t            status;
	} cmd_t;

	// Type-declaring opcodes
	function automatic logic is_type_op(input logic [15:0] op);
		is_type_op = (op inside {[OP_TYPE_VOID:OP_TYPE_LAST], OP_TYPE_POINTER,
			OP_TYPE_FUNCTION});
	endfunction

endpackage

>>> hw/rtl/spirv_module_indexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spirv_module_indexer: streaming index builder for a SPIR-V module
// Input queue side: push an item (action, word) while full is low; one word
// per item, then a finish item (action = 1) that yields the summary record.
// Result queue side: while empty is low the oldest record is on the result
// ports; pop takes it. Name, definition and decoration records come from
// words that name a valid id; other words give no record.
// Throughput: one item per cycle while full is low. A record passes from the
// decoder through the queue, the table read stage and the result register.
// Decoration links come from a per-id head table with one read and one write
// port; a same-id write in flight is forwarded to the following read.
// Reset and each summary start a clearing pass over all MAX_IDS entries of the
// head table; full stays high during the pass.
// When the receiver stalls, the result register holds, the table stage and
// the record queue fill, and full rises once the queue is full.
// ----------------------------------------------------------------------------
module spirv_module_indexer import smi_pkg::*; #(
	parameter int MAX_IDS  = 4096,
	parameter int POS_BITS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              action,
	input  logic [31:0]       word,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        record_kind,
	output logic [31:0]       target_id,
	output logic [OFF_W-1:0]  word_offset,
	output logic [15:0]       opcode,
	output logic [OFF_W-1:0]  prior_link,
	output logic [OFF_W-1:0]  types_at,
	output logic [OFF_W-1:0]  funcs_at,
	output logic [OFF_W-1:0]  names_at,
	output logic [TYPE_W-1:0] int32_type,
	output logic [TYPE_W-1:0] float32_type,
	output logic [TYPE_W-1:0] voidfunc_type,
	output logic [2:0]        status
);

	logic in_acc, emit, q_full, q_valid, q_pop, clr_busy, rec_valid;
	cmd_t cmd, q_cmd, rec;

	assign full   = q_full || clr_busy;
	assign in_acc = push && !full;

	// Decoder
	smi_front #(
		.MAX_IDS  (MAX_IDS),
		.POS_BITS (POS_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_acc (in_acc),
		.action (action),
		.word   (word),
		.emit   (emit),
		.cmd    (cmd)
	);

	// Record queue
	smi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_acc && emit),
		.wr_cmd   (cmd),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_cmd   (q_cmd),
		.full     (q_full)
	);

	// Table stage and result register
	smi_back #(
		.MAX_IDS (MAX_IDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.clr_busy  (clr_busy),
		.rec_valid (rec_valid),
		.rec       (rec),
		.rec_link  (prior_link),
		.rec_pop   (pop)
	);

	// Result ports
	assign empty         = !rec_valid;
	assign record_kind   = rec.kind;
	assign target_id     = rec.target_id;
	assign word_offset   = rec.word_offset;
	assign opcode        = rec.opcode;
	assign types_at      = rec.types_at;
	assign funcs_at      = rec.funcs_at;
	assign names_at      = rec.names_at;
	assign int32_type    = rec.int32_type;
	assign float32_type  = rec.float32_type;
	assign voidfunc_type = rec.voidfunc_type;
	assign status        = rec.status;

endmodule

>>> hw/rtl/smi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_front: word decoder
// Walks the header and the instruction stream one word per cycle while an item
// is accepted, keeps the layout marks, entry point and type ids, and builds one
// record per item that produces a result.
// ----------------------------------------------------------------------------
module smi_front import smi_pkg::*; #(
	parameter int MAX_IDS  = 4096,
	parameter int POS_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_acc,
	input  logic        action,
	input  logic [31:0] word,
	output logic        emit,
	output cmd_t        cmd
);

	localparam int ID_W = $clog2(MAX_IDS);
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [31:0] MAX_IDS_W = 32'(MAX_IDS);

	logic [POS_BITS-1:0] pos_q, pos_d, start_q, start_d;
	logic [15:0]         wii_q, wii_d, op_q, op_d, len_q, len_d;
	logic [ID_W-1:0]     op1_q, op1_d, void_q, void_d;
	logic                op_ok_q, op_ok_d, width_ok_q, width_ok_d;
	logic [31:0]         bound_q, bound_d, ep_id_q, ep_id_d;
	logic                stopped_q, stopped_d;
	logic [POS_BITS-1:0] dstart_q, dstart_d, dend_q, dend_d, pend_q, pend_d;
	logic [POS_BITS-1:0] ep_loc_q, ep_loc_d;
	logic [TYPE_W-1:0]   int_q, int_d, flt_q, flt_d, vfn_q, vfn_d;
	status_t             err_q, err_d;
	logic                id_ok;
	logic [15:0]         wii_inc;
	logic [15:0]         new_op, new_len;

	assign id_ok   = (word < bound_q) && (word < MAX_IDS_W);
	assign wii_inc = wii_q + 16'd1;
	assign new_op  = word[15:0];
	assign new_len = word[31:16];

	// Decode of one item
	always_comb begin
		pos_d      = pos_q;
		start_d    = start_q;
		wii_d      = wii_q;
		op_d       = op_q;
		len_d      = len_q;
		op1_d      = op1_q;
		op_ok_d    = op_ok_q;
		width_ok_d = width_ok_q;
		bound_d    = bound_q;
		stopped_d  = stopped_q;
		dstart_d   = dstart_q;
		dend_d     = dend_q;
		pend_d     = pend_q;
		ep_id_d    = ep_id_q;
		ep_loc_d   = ep_loc_q;
		void_d     = void_q;
		int_d      = int_q;
		flt_d      = flt_q;
		vfn_d      = vfn_q;
		err_d      = err_q;
		emit       = 1'b0;
		cmd        = '0;
		cmd.word_offset = OFF_W'(start_q);

		if (action) begin
			// Summary, then back to the reset state
			emit              = 1'b1;
			cmd.kind          = REC_SUMMARY;
			cmd.target_id     = ep_id_q;
			cmd.word_offset   = OFF_W'(ep_loc_q);
			cmd.types_at      = OFF_W'(dstart_q);
			cmd.funcs_at      = OFF_W'(dend_q);
			cmd.names_at      = OFF_W'(pend_q);
			cmd.int32_type    = int_q;
			cmd.float32_type  = flt_q;
			cmd.voidfunc_type = vfn_q;
			if (pos_q < POS_BITS'(HDR_WORDS)) begin
				cmd.status = ST_TOO_SHORT;
			end else if (err_q != ST_OK) begin
				cmd.status = err_q;
			end else if (ep_id_q == '0) begin
				cmd.status = ST_NO_ENTRY;
			end else begin
				cmd.status = ST_OK;
			end
			pos_d = '0; start_d = '0; wii_d = '0; op_d = '0; len_d = '0;
			op1_d = '0; op_ok_d = 1'b0; width_ok_d = 1'b0; bound_d = '0;
			stopped_d = 1'b0; dstart_d = '0; dend_d = '0; pend_d = '0;
			ep_id_d = '0; ep_loc_d = '0; void_d = '0; int_d = '0; flt_d = '0;
			vfn_d = '0; err_d = ST_OK;
		end else if (pos_q == POS_MAX) begin
			stopped_d = 1'b1;
		end else begin
			pos_d = pos_q + 1'b1;
			if (pos_q < POS_BITS'(HDR_WORDS)) begin
				if (pos_q == POS_BITS'(HDR_BOUND_WORD)) begin
					bound_d = word;
				end
			end else if (!stopped_q) begin
				if (wii_q == '0) begin
					// First word of an instruction
					start_d    = pos_q;
					op_d       = new_op;
					len_d      = new_len;
					op_ok_d    = 1'b0;
					width_ok_d = 1'b0;
					if (new_len == '0) begin
						stopped_d = 1'b1;
					end else begin
						if ((new_op == OP_NAME || new_op == OP_MEMBER_NAME) &&
							pend_q == '0) begin
							pend_d = pos_q;
						end
						if (is_type_op(new_op) && dstart_q == '0) begin
							dstart_d = pos_q;
						end
						if (new_op == OP_FUNCTION && dend_q == '0) begin
							dend_d = pos_q;
						end
						if (new_op == OP_ENTRY_POINT && ep_id_q != '0 &&
							err_q == ST_OK) begin
							err_d = ST_EXTRA_ENTRY;
						end
						wii_d = (new_len == 16'd1) ? 16'd0 : 16'd1;
					end
				end else begin
					// Operand words
					if (wii_q == 16'd1) begin
						if (op_q == OP_NAME) begin
							if (id_ok) begin
								emit          = 1'b1;
								cmd.kind      = REC_NAME;
								cmd.target_id = word;
							end else if (err_q == ST_OK) begin
								err_d = ST_BAD_ID;
							end
						end else if (is_type_op(op_q)) begin
							op1_d   = ID_W'(word);
							op_ok_d = id_ok;
							if (id_ok) begin
								if (op_q == OP_TYPE_VOID) begin
									void_d = ID_W'(word);
								end
								emit          = 1'b1;
								cmd.kind      = REC_DEFINITION;
								cmd.target_id = word;
								cmd.opcode    = op_q;
							end else if (err_q == ST_OK) begin
								err_d = ST_BAD_ID;
							end
						end else if (op_q == OP_DECORATE) begin
							if (id_ok) begin
								emit          = 1'b1;
								cmd.kind      = REC_DECORATION;
								cmd.target_id = word;
							end else if (err_q == ST_OK) begin
								err_d = ST_BAD_ID;
							end
						end
					end else if (wii_q == 16'd2) begin
						case (op_q)
							OP_CONSTANT, OP_FUNCTION, OP_VARIABLE: begin
								if (id_ok) begin
									emit          = 1'b1;
									cmd.kind      = REC_DEFINITION;
									cmd.target_id = word;
									cmd.opcode    = op_q;
								end else if (err_q == ST_OK) begin
									err_d = ST_BAD_ID;
								end
							end
							OP_TYPE_INT: begin
								width_ok_d = (word == SCALAR_BITS_32);
							end
							OP_TYPE_FLOAT: begin
								if (op_ok_q && word == SCALAR_BITS_32) begin
									flt_d = TYPE_W'(op1_q);
								end
							end
							OP_TYPE_FUNCTION: begin
								if (op_ok_q && word == 32'(void_q) && len_q == 16'd3) begin
									vfn_d = TYPE_W'(op1_q);
								end
							end
							OP_ENTRY_POINT: begin
								ep_id_d  = word;
								ep_loc_d = start_q;
							end
							default: begin
							end
						endcase
					end else if (wii_q == 16'd3) begin
						// Signedness word of an int type: unsigned only
						if (op_q == OP_TYPE_INT && op_ok_q && width_ok_q && word == '0) begin
							int_d = TYPE_W'(op1_q);
						end
					end
					wii_d = (wii_inc >= len_q) ? 16'd0 : wii_inc;
				end
			end
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			start_q    <= '0;
			wii_q      <= '0;
			op_q       <= '0;
			len_q      <= '0;
			op1_q      <= '0;
			op_ok_q    <= 1'b0;
			width_ok_q <= 1'b0;
			bound_q    <= '0;
			stopped_q  <= 1'b0;
			dstart_q   <= '0;
			dend_q     <= '0;
			pend_q     <= '0;
			ep_id_q    <= '0;
			ep_loc_q   <= '0;
			void_q     <= '0;
			int_q      <= '0;
			flt_q      <= '0;
			vfn_q      <= '0;
			err_q      <= ST_OK;
		end else if (in_acc) begin
			pos_q      <= pos_d;
			start_q    <= start_d;
			wii_q      <= wii_d;
			op_q       <= op_d;
			len_q      <= len_d;
			op1_q      <= op1_d;
			op_ok_q    <= op_ok_d;
			width_ok_q <= width_ok_d;
			bound_q    <= bound_d;
			stopped_q  <= stopped_d;
			dstart_q   <= dstart_d;
			dend_q     <= dend_d;
			pend_q     <= pend_d;
			ep_id_q    <= ep_id_d;
			ep_loc_q   <= ep_loc_d;
			void_q     <= void_d;
			int_q      <= int_d;
			flt_q      <= flt_d;
			vfn_q      <= vfn_d;
			err_q      <= err_d;
		end
	end

endmodule

>>> hw/rtl/smi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_queue: record queue
// Small FIFO of records between the decoder and the table stage.
// ----------------------------------------------------------------------------
module smi_queue import smi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	input  logic rd_en,
	output logic rd_valid,
	output cmd_t rd_cmd,
	output logic full
);

	localparam int QA_W = $clog2(QUEUE_DEPTH);

	cmd_t            slot_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QA_W:0]   count_q;

	assign full     = (count_q == (QA_W+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

>>> hw/rtl/smi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_back: decoration table stage and result register
// Reads the per-id head table for decoration records, writes the new head,
// and holds the finished record for the receiver. Clears the table after
// reset and after each summary.
// ----------------------------------------------------------------------------
module smi_back import smi_pkg::*; #(
	parameter int MAX_IDS = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  cmd_t             q_cmd,
	output logic             q_pop,
	output logic             clr_busy,
	output logic             rec_valid,
	output cmd_t             rec,
	output logic [OFF_W-1:0] rec_link,
	input  logic             rec_pop
);

	localparam int ID_W = $clog2(MAX_IDS);
	localparam logic [ID_W-1:0] CLR_LAST = ID_W'(MAX_IDS - 1);

	logic [OFF_W-1:0] head_mem [MAX_IDS];

	logic             v_s1, fwd_s1;
	cmd_t             cmd_s1;
	logic [OFF_W-1:0] fwd_val_s1, rdata_q;
	logic             out_v_q;
	cmd_t             rec_q;
	logic [OFF_W-1:0] link_q;
	logic             clr_busy_q;
	logic [ID_W-1:0]  clr_idx_q;

	logic [ID_W-1:0] rd_addr, addr_s1;
	logic            dec_s1, sum_s1, out_free, s1_move, load;

	assign rd_addr  = q_cmd.target_id[ID_W-1:0];
	assign addr_s1  = cmd_s1.target_id[ID_W-1:0];
	assign dec_s1   = v_s1 && (cmd_s1.kind == REC_DECORATION);
	assign sum_s1   = v_s1 && (cmd_s1.kind == REC_SUMMARY);
	assign out_free = !out_v_q || rec_pop;
	assign s1_move  = v_s1 && out_free;
	// A summary in s1 holds off loads so the clear sees no later lookup
	assign load     = q_valid && !clr_busy_q && !sum_s1 && (!v_s1 || s1_move);

	assign q_pop     = load;
	assign clr_busy  = clr_busy_q;
	assign rec_valid = out_v_q;
	assign rec       = rec_q;
	assign rec_link  = link_q;

	// Stage control, result valid and clear sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			out_v_q    <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			if (load) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_v_q <= 1'b1;
			end else if (rec_pop) begin
				out_v_q <= 1'b0;
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == CLR_LAST) begin
					clr_busy_q <= 1'b0;
				end
			end else if (s1_move && sum_s1) begin
				clr_busy_q <= 1'b1;
				clr_idx_q  <= '0;
			end
		end
	end

	// Stage 1 payload; forward a head written in the same cycle as the read
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1     <= q_cmd;
			fwd_s1     <= dec_s1 && s1_move && (addr_s1 == rd_addr);
			fwd_val_s1 <= cmd_s1.word_offset;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s1_move) begin
			rec_q  <= cmd_s1;
			link_q <= dec_s1 ? (fwd_s1 ? fwd_val_s1 : rdata_q) : '0;
		end
	end

	// Head table read port
	always_ff @(posedge clk) begin
		if (load) begin
			rdata_q <= head_mem[rd_addr];
		end
	end

	// Head table write port: clearing pass or new head
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			head_mem[clr_idx_q] <= '0;
		end else if (s1_move && dec_s1) begin
			head_mem[addr_s1] <= cmd_s1.word_offset;
		end
	end

endmodule

>>> hw/rtl/smi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_checker: port-level checks of the module indexer
// Watches the result side: record fields that must be zero for a kind, the
// status range, and a held record under stall.
// ----------------------------------------------------------------------------
module smi_checker import smi_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input logic [1:0]        record_kind,
	input logic [31:0]       target_id,
	input logic [OFF_W-1:0]  word_offset,
	input logic [15:0]       opcode,
	input logic [OFF_W-1:0]  prior_link,
	input logic [OFF_W-1:0]  types_at,
	input logic [OFF_W-1:0]  funcs_at,
	input logic [OFF_W-1:0]  names_at,
	input logic [TYPE_W-1:0] int32_type,
	input logic [TYPE_W-1:0] float32_type,
	input logic [TYPE_W-1:0] voidfunc_type,
	input logic [2:0]        status
);

	logic is_sum;
	assign is_sum = (record_kind == REC_SUMMARY);

	// A stalled record holds its kind and id
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(record_kind) && $stable(target_id))
		else $error("record changed while stalled");

	// Summary fields are zero outside the summary
	a_sum_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !is_sum |-> types_at == '0 && funcs_at == '0 &&
			names_at == '0 && int32_type == '0 && float32_type == '0 &&
			voidfunc_type == '0 && status == ST_OK)
		else $error("summary field set in a non-summary record");

	// Only definitions carry an opcode
	a_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && record_kind != REC_DEFINITION |-> opcode == '0)
		else $error("opcode set outside a definition record");

	// Only decorations carry a link, and a link points to an earlier word
	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((record_kind == REC_DECORATION) ? (prior_link < word_offset) :
			(prior_link == '0)))
		else $error("unexpected decoration link");

	// Summary status stays in its code range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && is_sum |-> status == ST_OK || status == ST_TOO_SHORT ||
			status == ST_BAD_ID || status == ST_EXTRA_ENTRY || status == ST_NO_ENTRY)
		else $error("summary status out of range");

endmodule

bind spirv_module_indexer smi_checker u_smi_checker (.*);

>>> verif/spirv_module_indexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spirv_module_indexer_tb: self-checking bench for the SPIR-V module indexer
// Streams modules word by word, keeps its own index of names, definitions,
// decoration chains, layout marks and known types, and compares every record
// the block emits against it. Directed modules hit the corner cases; random
// modules with random content and broken instructions do the bulk, under
// three idling phases on both queue sides.
// ----------------------------------------------------------------------------
module spirv_module_indexer_tb;
	import smi_pkg::*;

	localparam int          MAX_IDS     = 4096;
	localparam int          POS_BITS    = 20;
	localparam int          ID_BITS     = $clog2(MAX_IDS);
	localparam logic [31:0] POS_LIMIT   = (32'd1 << POS_BITS) - 1;
	localparam int          DRAIN_LIMIT = 50000;

	// expected record, field for field as on the result ports
	typedef struct packed {
		rec_kind_t          kind;
		logic [31:0]        target;
		logic [OFF_W-1:0]   offset;
		logic [15:0]        opc;
		logic [OFF_W-1:0]   link;
		logic [OFF_W-1:0]   types_at;
		logic [OFF_W-1:0]   funcs_at;
		logic [OFF_W-1:0]   names_at;
		logic [TYPE_W-1:0]  int32;
		logic [TYPE_W-1:0]  float32;
		logic [TYPE_W-1:0]  vfunc;
		status_t            st;
	} index_rec_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              action = 1'b0;
	logic [31:0]       word = 32'd0;
	logic              pop = 1'b0;
	logic              full;
	logic              empty;
	logic [1:0]        record_kind;
	logic [31:0]       target_id;
	logic [OFF_W-1:0]  word_offset;
	logic [15:0]       opcode;
	logic [OFF_W-1:0]  prior_link;
	logic [OFF_W-1:0]  types_at;
	logic [OFF_W-1:0]  funcs_at;
	logic [OFF_W-1:0]  names_at;
	logic [TYPE_W-1:0] int32_type;
	logic [TYPE_W-1:0] float32_type;
	logic [TYPE_W-1:0] voidfunc_type;
	logic [2:0]        status;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int records_checked = 0;
	int summaries_checked = 0;
	int items_sent = 0;

	index_rec_t  pending_records[$];
	logic [31:0] module_words[$];

	// random module generation state
	bit          gen_clean;
	logic [31:0] gen_bound;
	logic [31:0] gen_void;

	// indexer state mirrored by the bench
	logic [31:0]      ix_pos, ix_start;
	int               ix_slot;
	logic [15:0]      ix_op, ix_len;
	logic [31:0]      ix_first;
	bit               ix_first_ok, ix_width_ok;
	logic [31:0]      ix_bound;
	bit               ix_halted;
	logic [31:0]      ix_types_at, ix_funcs_at, ix_names_at;
	logic [31:0]      ix_entry_id, ix_entry_pos;
	logic [31:0]      ix_void, ix_int32, ix_float32, ix_vfunc;
	status_t          ix_err;
	logic [OFF_W-1:0] ix_heads[MAX_IDS];

	spirv_module_indexer #(
		.MAX_IDS (MAX_IDS),
		.POS_BITS(POS_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.word         (word),
		.empty        (empty),
		.pop          (pop),
		.record_kind  (record_kind),
		.target_id    (target_id),
		.word_offset  (word_offset),
		.opcode       (opcode),
		.prior_link   (prior_link),
		.types_at     (types_at),
		.funcs_at     (funcs_at),
		.names_at     (names_at),
		.int32_type   (int32_type),
		.float32_type (float32_type),
		.voidfunc_type(voidfunc_type),
		.status       (status)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#(64'd60_000_000);
		$display("spirv_module_indexer test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Index predictor
	// ------------------------------------------------------------------
	task automatic clear_index();
		ix_pos = '0;
		ix_start = '0;
		ix_slot = 0;
		ix_op = '0;
		ix_len = '0;
		ix_first = '0;
		ix_first_ok = 1'b0;
		ix_width_ok = 1'b0;
		ix_bound = '0;
		ix_halted = 1'b0;
		ix_types_at = '0;
		ix_funcs_at = '0;
		ix_names_at = '0;
		ix_entry_id = '0;
		ix_entry_pos = '0;
		ix_void = '0;
		ix_int32 = '0;
		ix_float32 = '0;
		ix_vfunc = '0;
		ix_err = ST_OK;
		for (int i = 0; i < MAX_IDS; i++) ix_heads[i] = '0;
	endtask

	// first error sticks
	function automatic void note_error(input status_t code);
		if (ix_err == ST_OK) ix_err = code;
	endfunction

	function automatic bit id_in_range(input logic [31:0] id);
		if (id < ix_bound && id < MAX_IDS) return 1'b1;
		note_error(ST_BAD_ID);
		return 1'b0;
	endfunction

	function automatic bit declares_type(input logic [15:0] op);
		return (op >= OP_TYPE_VOID && op <= OP_TYPE_LAST) || op == OP_TYPE_POINTER ||
			op == OP_TYPE_FUNCTION;
	endfunction

	function automatic void add_record(input rec_kind_t k, input logic [31:0] id,
		input logic [15:0] opc, input logic [OFF_W-1:0] link);
		index_rec_t rec;
		rec = '0;
		rec.kind = k;
		rec.target = id;
		rec.offset = ix_start[OFF_W-1:0];
		rec.opc = opc;
		rec.link = link;
		pending_records.push_back(rec);
	endfunction

	// operand words of the current instruction
	function automatic void index_operand(input logic [31:0] w);
		case (ix_slot)
			1: begin
				if (ix_op == OP_NAME) begin
					if (id_in_range(w)) add_record(REC_NAME, w, '0, '0);
				end else if (declares_type(ix_op)) begin
					ix_first = w;
					ix_first_ok = id_in_range(w);
					if (ix_first_ok) begin
						if (ix_op == OP_TYPE_VOID) ix_void = w;
						add_record(REC_DEFINITION, w, ix_op, '0);
					end
				end else if (ix_op == OP_DECORATE) begin
					if (id_in_range(w)) begin
						add_record(REC_DECORATION, w, '0, ix_heads[w[ID_BITS-1:0]]);
						ix_heads[w[ID_BITS-1:0]] = ix_start[OFF_W-1:0];
					end
				end
			end
			2: begin
				if (ix_op == OP_CONSTANT || ix_op == OP_FUNCTION || ix_op == OP_VARIABLE) begin
					if (id_in_range(w)) add_record(REC_DEFINITION, w, ix_op, '0);
				end else if (ix_op == OP_TYPE_INT) begin
					ix_width_ok = (w == SCALAR_BITS_32);
				end else if (ix_op == OP_TYPE_FLOAT) begin
					if (ix_first_ok && w == SCALAR_BITS_32) ix_float32 = ix_first;
				end else if (ix_op == OP_TYPE_FUNCTION) begin
					if (ix_first_ok && w == ix_void && ix_len == 16'd3) ix_vfunc = ix_first;
				end else if (ix_op == OP_ENTRY_POINT) begin
					ix_entry_id = w;
					ix_entry_pos = ix_start;
				end
			end
			3: begin
				// unsigned 32-bit int only
				if (ix_op == OP_TYPE_INT && ix_first_ok && ix_width_ok && w == 32'd0)
					ix_int32 = ix_first;
			end
			default: ;
		endcase
	endfunction

	function automatic void index_word(input logic [31:0] w);
		logic [31:0] p;
		p = ix_pos;
		// position counter saturated: ignore the rest of the module
		if (p >= POS_LIMIT) begin
			ix_halted = 1'b1;
			return;
		end
		ix_pos = p + 1;
		if (p < HDR_WORDS) begin
			if (p == HDR_BOUND_WORD) ix_bound = w;
			return;
		end
		if (ix_halted) return;
		if (ix_slot == 0) begin
			ix_start = p;
			ix_op = w[15:0];
			ix_len = w[31:16];
			ix_first_ok = 1'b0;
			ix_width_ok = 1'b0;
			if (ix_len == 16'd0) begin
				ix_halted = 1'b1;
				return;
			end
			if ((ix_op == OP_NAME || ix_op == OP_MEMBER_NAME) && ix_names_at == 0)
				ix_names_at = ix_start;
			if (declares_type(ix_op) && ix_types_at == 0) ix_types_at = ix_start;
			if (ix_op == OP_FUNCTION && ix_funcs_at == 0) ix_funcs_at = ix_start;
			if (ix_op == OP_ENTRY_POINT && ix_entry_id != 0) note_error(ST_EXTRA_ENTRY);
			ix_slot = (ix_len == 16'd1) ? 0 : 1;
		end else begin
			index_operand(w);
			ix_slot++;
			if (ix_slot >= ix_len) ix_slot = 0;
		end
	endfunction

	// summary record, then back to the reset state
	task automatic finish_module();
		index_rec_t rec;
		rec = '0;
		rec.kind = REC_SUMMARY;
		rec.target = ix_entry_id;
		rec.offset = ix_entry_pos[OFF_W-1:0];
		rec.types_at = ix_types_at[OFF_W-1:0];
		rec.funcs_at = ix_funcs_at[OFF_W-1:0];
		rec.names_at = ix_names_at[OFF_W-1:0];
		rec.int32 = ix_int32[TYPE_W-1:0];
		rec.float32 = ix_float32[TYPE_W-1:0];
		rec.vfunc = ix_vfunc[TYPE_W-1:0];
		if (ix_pos < HDR_WORDS) rec.st = ST_TOO_SHORT;
		else if (ix_err != ST_OK) rec.st = ix_err;
		else if (ix_entry_id == 0) rec.st = ST_NO_ENTRY;
		else rec.st = ST_OK;
		pending_records.push_back(rec);
		clear_index();
	endtask

	// ------------------------------------------------------------------
	// Item driver and record checker
	// ------------------------------------------------------------------
	task automatic send_item(input logic act, input logic [31:0] w);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		push <= 1'b1;
		action <= act;
		word <= w;
		do @(posedge clk); while (full !== 1'b0);
		if (act) finish_module();
		else index_word(w);
		items_sent++;
	endtask

	task automatic send_module();
		foreach (module_words[i]) send_item(1'b0, module_words[i]);
		send_item(1'b1, $urandom());
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t: record %0d %s: got 0x%0h, expected 0x%0h", $realtime,
				records_checked, what, got, want);
	endtask

	task automatic check_record();
		index_rec_t exp_rec;
		if (pending_records.size() == 0) begin
			report_mismatch("arrived with none pending, kind", record_kind, '0);
		end else begin
			exp_rec = pending_records.pop_front();
			if (record_kind !== exp_rec.kind) report_mismatch("kind", record_kind, exp_rec.kind);
			if (target_id !== exp_rec.target) report_mismatch("target_id", target_id, exp_rec.target);
			if (word_offset !== exp_rec.offset)
				report_mismatch("word_offset", word_offset, exp_rec.offset);
			if (opcode !== exp_rec.opc) report_mismatch("opcode", opcode, exp_rec.opc);
			if (prior_link !== exp_rec.link) report_mismatch("prior_link", prior_link, exp_rec.link);
			if (types_at !== exp_rec.types_at)
				report_mismatch("types_at", types_at, exp_rec.types_at);
			if (funcs_at !== exp_rec.funcs_at)
				report_mismatch("funcs_at", funcs_at, exp_rec.funcs_at);
			if (names_at !== exp_rec.names_at)
				report_mismatch("names_at", names_at, exp_rec.names_at);
			if (int32_type !== exp_rec.int32) report_mismatch("int32_type", int32_type, exp_rec.int32);
			if (float32_type !== exp_rec.float32)
				report_mismatch("float32_type", float32_type, exp_rec.float32);
			if (voidfunc_type !== exp_rec.vfunc)
				report_mismatch("voidfunc_type", voidfunc_type, exp_rec.vfunc);
			if (status !== exp_rec.st) report_mismatch("status", status, exp_rec.st);
			if (exp_rec.kind == REC_SUMMARY) summaries_checked++;
		end
		records_checked++;
	endtask

	// receiver: random pop, record taken at the edge where pop meets !empty
	always @(posedge clk) begin
		if (arst_n && pop && empty === 1'b0) check_record();
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------
	// Module builders
	// ------------------------------------------------------------------
	function automatic void put_header(input logic [31:0] bound);
		module_words.push_back(32'h0723_0203);
		module_words.push_back(32'h0001_0000);
		module_words.push_back(32'h0000_0000);
		module_words.push_back(bound);
		module_words.push_back(32'h0000_0000);
	endfunction

	function automatic void put_instr(input logic [15:0] len, input logic [15:0] op,
		input logic [31:0] a, input logic [31:0] b = 0, input logic [31:0] c = 0,
		input logic [31:0] d = 0);
		logic [31:0] ops[4];
		ops = '{a, b, c, d};
		module_words.push_back({len, op});
		for (int i = 0; i < 4 && i < int'(len) - 1; i++) module_words.push_back(ops[i]);
	endfunction

	// mostly small valid ids, now and then out of range or at the edges
	function automatic logic [31:0] pick_id();
		if (gen_clean) return $urandom_range(1, 24);
		case ($urandom_range(39))
			0: return $urandom();
			1: return MAX_IDS - 1;
			2: return gen_bound;
			3: return MAX_IDS;
			4: return 32'd0;
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	// one random instruction; forced_kind < 0 picks the kind at random
	function automatic void add_instr(input int forced_kind);
		logic [31:0] body[8];
		logic [15:0] op;
		logic [15:0] len;
		int norm;
		int kind;
		int roll;
		for (int i = 0; i < 8; i++) body[i] = $urandom();
		roll = $urandom_range(99);
		if (forced_kind < 0 && roll < 3) begin
			// zero length: decoding stops
			module_words.push_back({16'd0, 16'($urandom())});
			return;
		end
		if (forced_kind < 0 && roll < 5) begin
			// noise word, usually a huge length
			module_words.push_back($urandom());
			return;
		end
		kind = (forced_kind < 0) ? $urandom_range(14) : forced_kind;
		case (kind)
			0: begin
				op = OP_NAME; norm = $urandom_range(2, 4); body[1] = pick_id();
			end
			1: begin
				op = OP_MEMBER_NAME; norm = 4; body[1] = pick_id(); body[2] = $urandom_range(7);
			end
			2: begin
				op = OP_ENTRY_POINT; norm = $urandom_range(3, 5);
				body[1] = $urandom_range(6); body[2] = pick_id();
			end
			3: begin
				op = OP_TYPE_VOID; norm = 2; body[1] = pick_id(); gen_void = body[1];
			end
			4: begin
				op = OP_TYPE_INT; norm = 4; body[1] = pick_id();
				body[2] = ($urandom_range(3) == 0) ? 32'd16 : SCALAR_BITS_32;
				body[3] = $urandom_range(1);
			end
			5: begin
				op = OP_TYPE_FLOAT; norm = 3; body[1] = pick_id();
				body[2] = ($urandom_range(3) == 0) ? 32'd64 : SCALAR_BITS_32;
			end
			6: begin
				op = 16'($urandom_range(int'(OP_TYPE_FLOAT) + 1, int'(OP_TYPE_LAST)));
				norm = $urandom_range(2, 4); body[1] = pick_id();
			end
			7: begin
				op = OP_TYPE_POINTER; norm = 4; body[1] = pick_id();
				body[2] = $urandom_range(12); body[3] = pick_id();
			end
			8: begin
				op = OP_TYPE_FUNCTION; norm = ($urandom_range(3) == 0) ? 4 : 3;
				body[1] = pick_id();
				body[2] = ($urandom_range(3) == 0) ? pick_id() : gen_void;
				body[3] = pick_id();
			end
			9: begin
				op = OP_CONSTANT; norm = $urandom_range(3, 4); body[1] = pick_id();
				body[2] = pick_id();
			end
			10: begin
				op = OP_FUNCTION; norm = 5; body[1] = pick_id(); body[2] = pick_id();
				body[3] = $urandom_range(3); body[4] = pick_id();
			end
			11: begin
				op = OP_VARIABLE; norm = 4; body[1] = pick_id(); body[2] = pick_id();
				body[3] = $urandom_range(12);
			end
			14: begin
				op = 16'($urandom()); norm = $urandom_range(1, 6);
			end
			default: begin
				op = OP_DECORATE; norm = $urandom_range(3, 4); body[1] = pick_id();
				body[2] = $urandom_range(47);
			end
		endcase
		// now and then too short or with extra operands
		if (norm > 1 && $urandom_range(7) == 0) len = 16'($urandom_range(1, norm - 1));
		else if ($urandom_range(15) == 0) len = 16'(norm + $urandom_range(1, 2));
		else len = 16'(norm);
		module_words.push_back({len, op});
		for (int i = 1; i < int'(len); i++) module_words.push_back(body[i]);
	endfunction

	function automatic void build_random_module();
		int drop;
		module_words.delete();
		// occasional module that ends inside the header
		if ($urandom_range(29) == 0) begin
			repeat ($urandom_range(4)) module_words.push_back($urandom());
			return;
		end
		gen_clean = ($urandom_range(2) == 0);
		if (gen_clean) gen_bound = $urandom_range(32, 4200);
		else begin
			case ($urandom_range(9))
				0: gen_bound = $urandom();
				1: gen_bound = 32'd0;
				2: gen_bound = 32'hFFFF_FFFF;
				3: gen_bound = MAX_IDS;
				default: gen_bound = $urandom_range(8, 4200);
			endcase
		end
		gen_void = $urandom_range(1, 24);
		repeat (3) module_words.push_back($urandom());
		module_words.push_back(gen_bound);
		module_words.push_back($urandom());
		if ($urandom_range(9) < 7) add_instr(2);
		repeat ($urandom_range(1, 12)) add_instr(-1);
		// finish in the middle of the last instruction
		if ($urandom_range(5) == 0) begin
			drop = $urandom_range(1, 3);
			while (drop > 0 && module_words.size() > 5) begin
				void'(module_words.pop_back());
				drop--;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// finish before the header is complete
	task automatic test_short_modules();
		send_item(1'b1, 32'hFFFF_FFFF);
		send_item(1'b0, 32'hFFFF_FFFF);
		send_item(1'b0, 32'h0000_0000);
		send_item(1'b0, 32'h5A5A_A5A5);
		send_item(1'b1, 32'h0000_0000);
	endtask

	// types, decoration chain, id past the table, short instruction, stop word
	task automatic test_typed_module();
		module_words.delete();
		put_header(32'hFFFF_FFFF);
		put_instr(3, OP_ENTRY_POINT, 0, 7);
		put_instr(2, OP_NAME, MAX_IDS - 1);
		put_instr(2, OP_TYPE_VOID, 1);
		put_instr(4, OP_TYPE_INT, 2, SCALAR_BITS_32, 0);
		put_instr(3, OP_TYPE_FLOAT, 3, SCALAR_BITS_32);
		put_instr(3, OP_TYPE_FUNCTION, 4, 1);
		put_instr(3, OP_DECORATE, 2, 0);
		put_instr(3, OP_DECORATE, 2, 1);
		put_instr(2, OP_NAME, MAX_IDS);
		put_instr(2, OP_TYPE_INT, 5);
		put_instr(5, OP_FUNCTION, 1, 9, 0, 4);
		module_words.push_back(32'h0000_FFFF);
		put_instr(2, OP_NAME, 6);
		send_module();
	endtask

	// a second entry point, then a module without one
	task automatic test_entry_points();
		module_words.delete();
		put_header(32'd16);
		put_instr(3, OP_ENTRY_POINT, 0, 5);
		put_instr(3, OP_ENTRY_POINT, 0, 6);
		put_instr(2, OP_NAME, 0);
		send_module();
		module_words.delete();
		put_header(32'd16);
		put_instr(2, OP_NAME, 0);
		send_module();
	endtask

	task automatic test_random_modules(input int n_items);
		int first_item;
		first_item = items_sent;
		while (items_sent - first_item < n_items) begin
			build_random_module();
			send_module();
		end
	endtask

	initial begin
		int cycles;
		clear_index();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 15;
		recv_idle_pct = 84;
		test_short_modules();
		test_typed_module();
		test_entry_points();
		test_random_modules(300);

		send_idle_pct = 84;
		recv_idle_pct = 15;
		test_random_modules(300);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_modules(280);
		push <= 1'b0;

		// drain the expected records
		cycles = 0;
		while (pending_records.size() != 0 && cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (pending_records.size() != 0) begin
			$display("%0d records never arrived", pending_records.size());
			$display("spirv_module_indexer test failed");
			$finish;
		end else begin
			repeat (16) @(posedge clk);
			$display("Streamed %0d items; checked %0d records, %0d of them module summaries.",
				items_sent, records_checked, summaries_checked);
			$display("Mismatches: %0d", mismatch_count);
			if (mismatch_count == 0) begin
				$display("spirv_module_indexer test passed");
			end else begin
				$display("spirv_module_indexer test failed");
			end
			$finish;
		end
	end

endmodule
